// ===== hw/rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, register codes and address constants of the video register
// port.
// ----------------------------------------------------------------------------
package vrp_pkg;

  // Bus access kind
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Register offsets within the register block
  localparam logic [2:0] REG_CTRL      = 3'd0;
  localparam logic [2:0] REG_MASK      = 3'd1;
  localparam logic [2:0] REG_STATUS    = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
  localparam logic [2:0] REG_OAM_DATA  = 3'd4;
  localparam logic [2:0] REG_SCROLL    = 3'd5;
  localparam logic [2:0] REG_VADDR     = 3'd6;
  localparam logic [2:0] REG_DATA      = 3'd7;

  // Video address map (14-bit decode)
  localparam logic [13:0] NAME_BASE  = 14'h2000;
  localparam logic [13:0] PAL_BASE   = 14'h3f00;
  localparam logic [13:0] PAL_MIRROR = 14'h3f10;
  localparam logic [13:0] PAL_END    = 14'h3f20;

  localparam logic [7:0]  STATUS_FLAGS = 8'hc0;
  localparam logic [15:0] STEP_ROW     = 16'd32;
  localparam logic [15:0] STEP_BYTE    = 16'd1;
  localparam int          CTRL_STEP_BIT = 2;

  // Configuration register word index
  localparam logic CFG_MIRROR = 1'b0;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_FETCH,
    ST_COPY
  } state_t;

  // Fold a nametable address into two 1 KiB pages.
  // mode 0: quarters map 0,0,1,1; mode 1: quarters map 0,1,0,1.
  function automatic logic [10:0] fold_name(input logic [13:0] addr, input logic mode);
    logic page;
    page = mode ? addr[10] : addr[11];
    return {page, addr[9:0]};
  endfunction

endpackage

// ===== hw/rtl/vrp_in_if.sv =====
// ----------------------------------------------------------------------------
// vrp_in_if
// Bus access channel into the video register port.
// ----------------------------------------------------------------------------
interface vrp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] pattern_rom_byte;

  modport source (output valid, action, reg_index, write_data, pattern_rom_byte,
                  input ready);
  modport sink (input valid, action, reg_index, write_data, pattern_rom_byte,
                output ready);
endinterface

// ===== hw/rtl/vrp_out_if.sv =====
// ----------------------------------------------------------------------------
// vrp_out_if
// Result channel out of the video register port.
// ----------------------------------------------------------------------------
interface vrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] video_address;

  modport source (output valid, read_data, video_address, input ready);
  modport sink (input valid, read_data, video_address, output ready);
endinterface

// ===== hw/rtl/vrp_ram.sv =====
// ----------------------------------------------------------------------------
// vrp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/video_register_port.sv =====
// ----------------------------------------------------------------------------
// video_register_port
// Register side of a tile video unit: control, mask, scroll, sprite-memory
// and video-address latches, buffered data port, nametable and palette RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  in_ch   | sink      | valid / ready    | action, reg_index, write_data,
//          |           |                  | pattern_rom_byte
//  out_ch  | source    | valid / ready    | read_data, video_address
//  cfg_*   | APB slave | psel/penable     | mirror_mode at byte address 0
//
//  Sprite data reads and data-port reads of the nametable pass through a
//  fetch state (registered RAM read); mirrored palette writes pass through
//  a copy state (second write on the palette RAM port). Reset is synchronous,
//  active low, and needs no clearing pass. A new transfer is taken only in
//  the accept state, once the result register is empty or being drained.
// ----------------------------------------------------------------------------
module video_register_port #(
  parameter int NAME_BYTES    = 2048,
  parameter int SPRITE_BYTES  = 256,
  parameter int COLOR_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  vrp_in_if.sink      in_ch,
  vrp_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NAW = $clog2(NAME_BYTES);
  localparam int SAW = $clog2(SPRITE_BYTES);
  localparam int CAW = $clog2(COLOR_ENTRIES);

  vrp_pkg::state_t state_r, state_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_read_data_r, out_read_data_nxt;
  logic [15:0] out_vaddr_r, out_vaddr_nxt;

  logic [15:0] vram_ptr_r, vram_ptr_nxt;
  logic        second_write_r, second_write_nxt;
  logic [7:0]  read_buf_r, read_buf_nxt;
  logic [7:0]  control_r, control_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  scroll_x_r, scroll_x_nxt;
  logic [7:0]  scroll_y_r, scroll_y_nxt;
  logic [7:0]  sprite_ptr_r, sprite_ptr_nxt;
  logic        status_phase_r, status_phase_nxt;
  logic        fetch_sprite_r, fetch_sprite_nxt;
  logic [CAW-1:0] copy_idx_r, copy_idx_nxt;
  logic [7:0]  copy_data_r, copy_data_nxt;
  logic        mirror_r;

  logic        in_ready_c;
  logic        in_accept;
  logic [13:0] vaddr;
  logic        is_rom, is_name, is_pal, is_pal_mirror;
  logic [15:0] ptr_step;

  logic           name_we, sprite_we, color_we;
  logic [NAW-1:0] name_idx;
  logic [SAW-1:0] sprite_idx;
  logic [CAW-1:0] color_idx;
  logic [7:0]     name_rdata, sprite_rdata;
  logic           cfg_write;

  // --------------------------------------------------------------------------
  // Address decode
  // --------------------------------------------------------------------------
  assign vaddr         = vram_ptr_r[13:0];
  assign is_rom        = vaddr < vrp_pkg::NAME_BASE;
  assign is_name       = !is_rom && (vaddr < vrp_pkg::PAL_BASE);
  assign is_pal        = (vaddr >= vrp_pkg::PAL_BASE) && (vaddr < vrp_pkg::PAL_END);
  assign is_pal_mirror = (vaddr >= vrp_pkg::PAL_MIRROR) && (vaddr < vrp_pkg::PAL_END) &&
                         (vaddr[1:0] == 2'b00);
  assign ptr_step      = control_r[vrp_pkg::CTRL_STEP_BIT] ? vrp_pkg::STEP_ROW
                                                           : vrp_pkg::STEP_BYTE;

  assign name_idx   = NAW'(vrp_pkg::fold_name(vaddr, mirror_r));
  assign sprite_idx = sprite_ptr_r[SAW-1:0];
  assign color_idx  = (state_r == vrp_pkg::ST_COPY) ? copy_idx_r : vaddr[CAW-1:0];

  assign in_accept = in_ch.valid && in_ready_c;

  // --------------------------------------------------------------------------
  // State machine: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vrp_pkg::ST_ACCEPT: begin
        if (in_accept) begin
          if (in_ch.action == vrp_pkg::ACT_READ) begin
            if (in_ch.reg_index == vrp_pkg::REG_OAM_DATA ||
                (in_ch.reg_index == vrp_pkg::REG_DATA && is_name)) begin
              state_nxt = vrp_pkg::ST_FETCH;
            end
          end else if (in_ch.reg_index == vrp_pkg::REG_DATA && is_pal_mirror) begin
            state_nxt = vrp_pkg::ST_COPY;
          end
        end
      end
      vrp_pkg::ST_FETCH: state_nxt = vrp_pkg::ST_ACCEPT;
      vrp_pkg::ST_COPY:  state_nxt = vrp_pkg::ST_ACCEPT;
      default:           state_nxt = vrp_pkg::ST_ACCEPT;
    endcase
  end

  // --------------------------------------------------------------------------
  // State machine: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_c = 1'b0;
    case (state_r)
      vrp_pkg::ST_ACCEPT: in_ready_c = !out_valid_r || out_ch.ready;
      vrp_pkg::ST_FETCH:  in_ready_c = 1'b0;
      vrp_pkg::ST_COPY:   in_ready_c = 1'b0;
      default:            in_ready_c = 1'b0;
    endcase
  end

  assign in_ch.ready = in_ready_c;

  // --------------------------------------------------------------------------
  // Datapath: register updates and RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    logic out_load;

    out_load          = 1'b0;
    out_read_data_nxt = out_read_data_r;
    out_vaddr_nxt     = out_vaddr_r;
    vram_ptr_nxt      = vram_ptr_r;
    second_write_nxt  = second_write_r;
    read_buf_nxt      = read_buf_r;
    control_nxt       = control_r;
    mask_nxt          = mask_r;
    scroll_x_nxt      = scroll_x_r;
    scroll_y_nxt      = scroll_y_r;
    sprite_ptr_nxt    = sprite_ptr_r;
    status_phase_nxt  = status_phase_r;
    fetch_sprite_nxt  = fetch_sprite_r;
    copy_idx_nxt      = copy_idx_r;
    copy_data_nxt     = copy_data_r;
    name_we           = 1'b0;
    sprite_we         = 1'b0;
    color_we          = 1'b0;

    if (in_accept) begin
      out_load          = 1'b1;
      out_read_data_nxt = 8'h00;
      if (in_ch.action == vrp_pkg::ACT_WRITE) begin
        case (in_ch.reg_index)
          vrp_pkg::REG_CTRL:     control_nxt = in_ch.write_data;
          vrp_pkg::REG_MASK:     mask_nxt = in_ch.write_data;
          vrp_pkg::REG_OAM_ADDR: sprite_ptr_nxt = in_ch.write_data;
          vrp_pkg::REG_OAM_DATA: begin
            sprite_we      = 1'b1;
            sprite_ptr_nxt = sprite_ptr_r + 8'd1;
          end
          vrp_pkg::REG_SCROLL: begin
            if (!second_write_r) begin
              scroll_x_nxt = in_ch.write_data;
            end else begin
              scroll_y_nxt = in_ch.write_data;
            end
            second_write_nxt = !second_write_r;
          end
          vrp_pkg::REG_VADDR: begin
            if (!second_write_r) begin
              vram_ptr_nxt = {in_ch.write_data, vram_ptr_r[7:0]};
            end else begin
              vram_ptr_nxt = {vram_ptr_r[15:8], in_ch.write_data};
            end
            second_write_nxt = !second_write_r;
          end
          vrp_pkg::REG_DATA: begin
            name_we  = is_name;
            color_we = is_pal;
            // Hold the copy to the low palette entry for the next cycle
            copy_idx_nxt  = CAW'(vaddr[3:0]);
            copy_data_nxt = in_ch.write_data;
            vram_ptr_nxt  = vram_ptr_r + ptr_step;
          end
          default: ;
        endcase
      end else begin
        case (in_ch.reg_index)
          vrp_pkg::REG_STATUS: begin
            second_write_nxt  = 1'b0;
            out_read_data_nxt = status_phase_r ? 8'h00 : vrp_pkg::STATUS_FLAGS;
            status_phase_nxt  = !status_phase_r;
          end
          vrp_pkg::REG_OAM_DATA: begin
            // Result waits for the registered sprite RAM read
            out_load         = 1'b0;
            fetch_sprite_nxt = 1'b1;
          end
          vrp_pkg::REG_DATA: begin
            out_read_data_nxt = read_buf_r;
            fetch_sprite_nxt  = 1'b0;
            if (is_rom) begin
              read_buf_nxt = in_ch.pattern_rom_byte;
            end else if (!is_name) begin
              read_buf_nxt = 8'h00;
            end
            vram_ptr_nxt = vram_ptr_r + ptr_step;
          end
          default: ;
        endcase
      end
      out_vaddr_nxt = vram_ptr_nxt;
    end

    if (state_r == vrp_pkg::ST_FETCH) begin
      if (fetch_sprite_r) begin
        out_load          = 1'b1;
        out_read_data_nxt = sprite_rdata;
        out_vaddr_nxt     = vram_ptr_r;
      end else begin
        read_buf_nxt = name_rdata;
      end
    end

    if (state_r == vrp_pkg::ST_COPY) begin
      color_we = 1'b1;
    end

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= vrp_pkg::ST_ACCEPT;
      out_valid_r    <= 1'b0;
      vram_ptr_r     <= '0;
      second_write_r <= 1'b0;
      read_buf_r     <= '0;
      control_r      <= '0;
      mask_r         <= '0;
      scroll_x_r     <= '0;
      scroll_y_r     <= '0;
      sprite_ptr_r   <= '0;
      status_phase_r <= 1'b0;
      fetch_sprite_r <= 1'b0;
      mirror_r       <= 1'b1;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      vram_ptr_r     <= vram_ptr_nxt;
      second_write_r <= second_write_nxt;
      read_buf_r     <= read_buf_nxt;
      control_r      <= control_nxt;
      mask_r         <= mask_nxt;
      scroll_x_r     <= scroll_x_nxt;
      scroll_y_r     <= scroll_y_nxt;
      sprite_ptr_r   <= sprite_ptr_nxt;
      status_phase_r <= status_phase_nxt;
      fetch_sprite_r <= fetch_sprite_nxt;
      if (cfg_write && cfg_paddr[2] == vrp_pkg::CFG_MIRROR) begin
        mirror_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_read_data_r <= out_read_data_nxt;
    out_vaddr_r     <= out_vaddr_nxt;
    copy_idx_r      <= copy_idx_nxt;
    copy_data_r     <= copy_data_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_read_data_r;
  assign out_ch.video_address = out_vaddr_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == vrp_pkg::CFG_MIRROR) ? {31'd0, mirror_r} : 32'd0;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  vrp_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
    .clk     (clk),
    .wr_en   (name_we),
    .wr_addr (name_idx),
    .wr_data (in_ch.write_data),
    .rd_addr (name_idx),
    .rd_data (name_rdata)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_sprite_ram (
    .clk     (clk),
    .wr_en   (sprite_we),
    .wr_addr (sprite_idx),
    .wr_data (in_ch.write_data),
    .rd_addr (sprite_idx),
    .rd_data (sprite_rdata)
  );

  // Palette is write-only from this side
  vrp_ram #(.WIDTH(8), .DEPTH(COLOR_ENTRIES)) u_color_ram (
    .clk     (clk),
    .wr_en   (color_we),
    .wr_addr (color_idx),
    .wr_data ((state_r == vrp_pkg::ST_COPY) ? copy_data_r : in_ch.write_data),
    .rd_addr (color_idx),
    .rd_data ()
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> state_r == vrp_pkg::ST_ACCEPT)
    else $error("transfer taken outside the accept state");

  a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vrp_pkg::ST_FETCH && fetch_sprite_r) |-> !out_valid_r)
    else $error("sprite read result would overwrite a pending result");

  a_status_clears_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.action == vrp_pkg::ACT_READ &&
     in_ch.reg_index == vrp_pkg::REG_STATUS) |=> !second_write_r)
    else $error("status read did not clear the write toggle");

  a_data_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.reg_index == vrp_pkg::REG_DATA) |=>
      vram_ptr_r == $past(vram_ptr_r) + $past(ptr_step))
    else $error("data port access did not advance the video address");

  a_copy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vrp_pkg::ST_COPY |-> $past(in_accept) && $past(is_pal_mirror))
    else $error("palette copy without a mirrored palette write");

endmodule
